[hdl/kpe_pkg.sv]
// kpe_pkg: shared constants, codes and types of the keypad pin entry collector
// no dependencies; imported by every module of the block except kpe_ram
`timescale 1ns / 1ps

package kpe_pkg;

  localparam int PIN_DEPTH = 28;
  localparam int LEN_W     = $clog2(PIN_DEPTH + 1);
  localparam int IDX_W     = $clog2(PIN_DEPTH);
  localparam int KEY_W     = 8;
  localparam int CD_W      = 16;
  localparam int PLEN_W    = 5;
  localparam int KIND_W    = 2;
  localparam int OP_W      = 2;
  localparam int OUT_DEPTH = 4;

  localparam logic [OP_W-1:0] OP_POLL  = 2'd0;
  localparam logic [OP_W-1:0] OP_KEY   = 2'd1;
  localparam logic [OP_W-1:0] OP_CARD  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  localparam logic [KEY_W-1:0] KEY_CLEAR = 8'h7f;
  localparam logic [KEY_W-1:0] KEY_ENTER = 8'h0d;

  localparam logic [KIND_W-1:0] KIND_ENTER    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT  = 2'd2;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_KEY_CLEAR,
    CMD_KEY_ENTER,
    CMD_KEY_STORE,
    CMD_CARD,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [KEY_W-1:0] key;
    logic             tick_after;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] pin_kind;
    logic [KEY_W-1:0]  digit;
    logic              digit_valid;
    logic [PLEN_W-1:0] pin_length;
    logic              last_digit;
  } result_t;

endpackage

[hdl/kpe_ram.sv]
// kpe_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module kpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 28
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/kpe_front.sv]
// kpe_front: accepts input words, classifies them into commands, holds a
// two entry command queue; depends on kpe_pkg
`timescale 1ns / 1ps

module kpe_front import kpe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [OP_W-1:0]  op_i,
  input  logic [KEY_W-1:0] key_code_i,
  input  logic             last_key_of_packet_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  logic             cmd_pop_i
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_in;
  logic       do_push, do_pop;

  always_comb begin
    cmd_in.key        = key_code_i;
    cmd_in.tick_after = 1'b0;
    unique case (op_i)
      OP_POLL:  cmd_in.kind = CMD_TICK;
      OP_KEY: begin
        cmd_in.tick_after = last_key_of_packet_i;
        if (key_code_i == KEY_CLEAR) begin
          cmd_in.kind = CMD_KEY_CLEAR;
        end else if (key_code_i == KEY_ENTER) begin
          cmd_in.kind = CMD_KEY_ENTER;
        end else begin
          cmd_in.kind = CMD_KEY_STORE;
        end
      end
      OP_CARD:  cmd_in.kind = CMD_CARD;
      OP_CLEAR: cmd_in.kind = CMD_CLEAR;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

[hdl/kpe_back.sv]
// kpe_back: entry state, pin store, readout sequencer and result queue
// depends on kpe_pkg and kpe_ram
`timescale 1ns / 1ps

module kpe_back import kpe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CD_W-1:0]  cfg_wdata_i,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             empty,
  input  logic             pop,
  output result_t          res_o
);

  localparam int OPTR_W = $clog2(OUT_DEPTH);
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic {ST_IDLE, ST_EMIT} state_e;

  state_e             state_q, state_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [CD_W-1:0]    cd_q, cd_d;
  logic [LEN_W-1:0]   idx_q, idx_d;
  logic [LEN_W-1:0]   last_q, last_d;
  logic [LEN_W-1:0]   elen_q, elen_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic               post_store_q, post_store_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic               rd_valid_q, rd_valid_d;
  result_t            meta_q, meta_d;
  logic [CD_W-1:0]    reload_q;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [KEY_W-1:0]   ram_wdata, ram_rdata;

  result_t            out_mem_q [OUT_DEPTH];
  logic [OPTR_W-1:0]  out_wr_q, out_rd_q;
  logic [OCNT_W-1:0]  out_cnt_q;
  logic [OCNT_W:0]    occ;
  logic               credit;
  logic               out_pop;
  result_t            push_res;

  kpe_ram #(
    .WIDTH (KEY_W),
    .DEPTH (PIN_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= '0;
    end else if (cfg_we_i) begin
      reload_q <= cfg_wdata_i;
    end
  end

  assign occ    = {1'b0, out_cnt_q} + {{OCNT_W{1'b0}}, rd_valid_q};
  assign credit = (occ < (OCNT_W + 1)'(OUT_DEPTH));

  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    cd_d         = cd_q;
    idx_d        = idx_q;
    last_d       = last_q;
    elen_d       = elen_q;
    kind_d       = kind_q;
    post_store_d = post_store_q;
    key_d        = key_q;
    rd_valid_d   = 1'b0;
    meta_d       = meta_q;
    cmd_pop_o    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = len_q[IDX_W-1:0];
    ram_wdata    = cmd_i.key;
    ram_re       = 1'b0;
    ram_raddr    = idx_q[IDX_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o    = 1'b1;
          idx_d        = '0;
          last_d       = (len_q == '0) ? '0 : len_q - LEN_W'(1);
          elen_d       = len_q;
          post_store_d = 1'b0;
          key_d        = cmd_i.key;
          case (cmd_i.kind)
            CMD_TICK: begin
              if (len_q != '0) begin
                if (cd_q != '0) begin
                  cd_d = cd_q - CD_W'(1);
                end else if (reload_q != '0) begin
                  kind_d  = KIND_TIMEOUT;
                  state_d = ST_EMIT;
                end
              end
            end
            CMD_KEY_CLEAR: begin
              len_d = '0;
              cd_d  = reload_q;
            end
            CMD_KEY_ENTER: begin
              cd_d    = reload_q;
              kind_d  = KIND_ENTER;
              state_d = ST_EMIT;
            end
            CMD_KEY_STORE: begin
              cd_d = (cmd_i.tick_after && reload_q != '0) ? reload_q - CD_W'(1) : reload_q;
              if (len_q == LEN_W'(PIN_DEPTH)) begin
                kind_d       = KIND_OVERFLOW;
                post_store_d = 1'b1;
                state_d      = ST_EMIT;
              end else begin
                ram_we = 1'b1;
                len_d  = len_q + LEN_W'(1);
              end
            end
            CMD_CARD: begin
              len_d = '0;
            end
            CMD_CLEAR: begin
              len_d = '0;
              cd_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (credit) begin
          ram_re             = (elen_q != '0);
          rd_valid_d         = 1'b1;
          meta_d.pin_kind    = kind_q;
          meta_d.digit       = '0;
          meta_d.digit_valid = (elen_q != '0);
          meta_d.pin_length  = PLEN_W'(elen_q);
          meta_d.last_digit  = (idx_q == last_q);
          idx_d              = idx_q + LEN_W'(1);
          if (idx_q == last_q) begin
            state_d = ST_IDLE;
            // overflow restarts the entry with the pending key in slot zero
            if (post_store_q) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = key_q;
              len_d     = LEN_W'(1);
            end else begin
              len_d = '0;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      len_q        <= '0;
      cd_q         <= '0;
      idx_q        <= '0;
      last_q       <= '0;
      elen_q       <= '0;
      kind_q       <= KIND_ENTER;
      post_store_q <= 1'b0;
      key_q        <= '0;
      rd_valid_q   <= 1'b0;
      meta_q       <= '0;
    end else begin
      state_q      <= state_d;
      len_q        <= len_d;
      cd_q         <= cd_d;
      idx_q        <= idx_d;
      last_q       <= last_d;
      elen_q       <= elen_d;
      kind_q       <= kind_d;
      post_store_q <= post_store_d;
      key_q        <= key_d;
      rd_valid_q   <= rd_valid_d;
      meta_q       <= meta_d;
    end
  end

  always_comb begin
    push_res       = meta_q;
    push_res.digit = meta_q.digit_valid ? ram_rdata : '0;
  end

  assign empty   = (out_cnt_q == '0);
  assign out_pop = pop && !empty;
  assign res_o   = out_mem_q[out_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (rd_valid_q) begin
        out_wr_q <= out_wr_q + OPTR_W'(1);
      end
      if (out_pop) begin
        out_rd_q <= out_rd_q + OPTR_W'(1);
      end
      out_cnt_q <= out_cnt_q + OCNT_W'(rd_valid_q) - OCNT_W'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      out_mem_q[out_wr_q] <= push_res;
    end
  end

endmodule

[hdl/keypad_pin_entry_collector.sv]
// keypad_pin_entry_collector: top level, joins the classifying front and the
// readout back; depends on kpe_pkg, kpe_front, kpe_back, kpe_ram
//
// Input channel: an event word (op, key code, end of packet flag) is taken
// at a rising edge with push high and full low. A two word command queue
// parts the front from the back.
// Result channel: while empty is low the oldest result word stands on the
// result ports; it leaves at a rising edge with pop high. A four word result
// queue holds finished words, so the receiver may stall at will; the back
// halts readout when that queue is full and resumes when room appears.
// Timing: the back takes one command per cycle when it causes no result.
// A command that emits a pin holds the back until each of its words is read
// through the single read port of the pin store (an empty enter gives one
// word); the first word passes command queue, emit state and read register.
// Configuration: cfg_we_i writes cfg_wdata_i into the timeout reload at once.
// Reset: entry empty, countdown and reload zero, both queues empty; the pin
// store is not cleared, since only written slots are ever read.
`timescale 1ns / 1ps

module keypad_pin_entry_collector import kpe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CD_W-1:0]   cfg_wdata_i,
  input  logic              push,
  output logic              full,
  input  logic [OP_W-1:0]   op_i,
  input  logic [KEY_W-1:0]  key_code_i,
  input  logic              last_key_of_packet_i,
  output logic              empty,
  input  logic              pop,
  output logic [KIND_W-1:0] pin_kind_o,
  output logic [KEY_W-1:0]  digit_o,
  output logic              digit_valid_o,
  output logic [PLEN_W-1:0] pin_length_o,
  output logic              last_digit_o
);

  logic    cmd_valid;
  logic    cmd_pop;
  cmd_t    cmd;
  result_t res;

  kpe_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .push                 (push),
    .full                 (full),
    .op_i                 (op_i),
    .key_code_i           (key_code_i),
    .last_key_of_packet_i (last_key_of_packet_i),
    .cmd_valid_o          (cmd_valid),
    .cmd_o                (cmd),
    .cmd_pop_i            (cmd_pop)
  );

  kpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign pin_kind_o    = res.pin_kind;
  assign digit_o       = res.digit;
  assign digit_valid_o = res.digit_valid;
  assign pin_length_o  = res.pin_length;
  assign last_digit_o  = res.last_digit;

  a_pop_only_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  a_empty_pin_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !digit_valid_o) |->
      (last_digit_o && pin_length_o == '0 && pin_kind_o == KIND_ENTER))
    else $error("malformed empty pin word");

  a_kind_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pin_kind_o == KIND_ENTER || pin_kind_o == KIND_OVERFLOW ||
                pin_kind_o == KIND_TIMEOUT))
    else $error("illegal pin kind in result queue");

  a_valid_pin_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && digit_valid_o) |-> (pin_length_o != '0))
    else $error("digit word with zero pin length");

endmodule

[tb/kpe_pin_monitor.sv]
// kpe_pin_monitor: watches the event, reload and result ports of the keypad pin
// entry collector, predicts every result word and compares; depends on kpe_pkg
`timescale 1ns / 1ps

module kpe_pin_monitor import kpe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CD_W-1:0]   cfg_wdata_i,
  input  logic              push_i,
  input  logic              full_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [KEY_W-1:0]  key_code_i,
  input  logic              last_key_of_packet_i,
  input  logic              empty_i,
  input  logic              pop_i,
  input  logic [KIND_W-1:0] pin_kind_i,
  input  logic [KEY_W-1:0]  digit_i,
  input  logic              digit_valid_i,
  input  logic [PLEN_W-1:0] pin_length_i,
  input  logic              last_digit_i,
  output int                mismatches_o,
  output int                words_due_o,
  output int                words_seen_o
);

  localparam int REPORT_CAP = 40;

  logic [KEY_W-1:0] pin_digits [PIN_DEPTH];
  int               entry_len;
  logic [CD_W-1:0]  countdown;
  logic [CD_W-1:0]  reload;
  result_t          pin_words_due [$];
  int               errors;
  int               seen;

  task automatic emit_pin(input logic [KIND_W-1:0] kind);
    result_t w;
    w.pin_kind = kind;
    if (entry_len == 0) begin
      w.digit       = '0;
      w.digit_valid = 1'b0;
      w.pin_length  = '0;
      w.last_digit  = 1'b1;
      pin_words_due.push_back(w);
    end else begin
      for (int i = 0; i < entry_len; i++) begin
        w.digit       = pin_digits[i];
        w.digit_valid = 1'b1;
        w.pin_length  = PLEN_W'(entry_len);
        w.last_digit  = (i == entry_len - 1);
        pin_words_due.push_back(w);
      end
    end
  endtask

  task automatic countdown_tick();
    if (entry_len > 0) begin
      if (countdown != '0) begin
        countdown = countdown - 1'b1;
      end else if (reload != '0) begin
        emit_pin(KIND_TIMEOUT);
        entry_len = 0;
      end
    end
  endtask

  task automatic collect_event(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                               input logic tick_after);
    case (op)
      OP_POLL: countdown_tick();
      OP_KEY: begin
        if (key == KEY_CLEAR) begin
          entry_len = 0;
        end else if (key == KEY_ENTER) begin
          emit_pin(KIND_ENTER);
          entry_len = 0;
        end else begin
          if (entry_len >= PIN_DEPTH) begin
            emit_pin(KIND_OVERFLOW);
            entry_len = 0;
          end
          pin_digits[entry_len] = key;
          entry_len++;
        end
        countdown = reload;
        if (tick_after) countdown_tick();
      end
      OP_CARD: entry_len = 0;
      default: begin
        countdown = '0;
        entry_len = 0;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      if (errors <= REPORT_CAP)
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t w;
    if (!rst_ni) begin
      reload    = '0;
      countdown = '0;
      entry_len = 0;
      errors    = 0;
      seen      = 0;
      pin_words_due.delete();
    end else begin
      if (cfg_we_i) reload = cfg_wdata_i;
      // pop first: a word leaving now was predicted by an earlier event
      if (pop_i && !empty_i) begin
        seen++;
        if (pin_words_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP) $error("result word with none expected");
        end else begin
          w = pin_words_due.pop_front();
          check_field("pin_kind", 16'(w.pin_kind), 16'(pin_kind_i));
          check_field("digit", 16'(w.digit), 16'(digit_i));
          check_field("digit_valid", 16'(w.digit_valid), 16'(digit_valid_i));
          check_field("pin_length", 16'(w.pin_length), 16'(pin_length_i));
          check_field("last_digit", 16'(w.last_digit), 16'(last_digit_i));
        end
      end
      if (push_i && !full_i) collect_event(op_i, key_code_i, last_key_of_packet_i);
    end
    mismatches_o <= errors;
    words_due_o  <= pin_words_due.size();
    words_seen_o <= seen;
  end

endmodule

[tb/tb_top.sv]
// tb_top: drives keypad events and reload writes into the pin entry collector
// with random idling on both sides; depends on kpe_pkg, kpe_pin_monitor and the collector
`timescale 1ns / 1ps

module tb_top;
  import kpe_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int SEGMENT_EVENTS = 75;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CD_W-1:0]   cfg_wdata = '0;
  logic              push = 1'b0;
  logic              full;
  logic [OP_W-1:0]   op = OP_POLL;
  logic [KEY_W-1:0]  key_code = '0;
  logic              last_key = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic [KIND_W-1:0] pin_kind;
  logic [KEY_W-1:0]  digit;
  logic              digit_valid;
  logic [PLEN_W-1:0] pin_length;
  logic              last_digit;

  int mismatches;
  int words_due;
  int words_seen;
  int sender_idle_pct = 37;
  int receiver_stall_pct = 74;
  int events_sent = 0;
  int quiet_cycles = 0;
  logic [CD_W-1:0] reload_now = '0;

  always #5 clk = ~clk;

  keypad_pin_entry_collector uut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_we_i             (cfg_we),
    .cfg_wdata_i          (cfg_wdata),
    .push                 (push),
    .full                 (full),
    .op_i                 (op),
    .key_code_i           (key_code),
    .last_key_of_packet_i (last_key),
    .empty                (empty),
    .pop                  (pop),
    .pin_kind_o           (pin_kind),
    .digit_o              (digit),
    .digit_valid_o        (digit_valid),
    .pin_length_o         (pin_length),
    .last_digit_o         (last_digit)
  );

  kpe_pin_monitor pin_monitor (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_we_i             (cfg_we),
    .cfg_wdata_i          (cfg_wdata),
    .push_i               (push),
    .full_i               (full),
    .op_i                 (op),
    .key_code_i           (key_code),
    .last_key_of_packet_i (last_key),
    .empty_i              (empty),
    .pop_i                (pop),
    .pin_kind_i           (pin_kind),
    .digit_i              (digit),
    .digit_valid_i        (digit_valid),
    .pin_length_i         (pin_length),
    .last_digit_i         (last_digit),
    .mismatches_o         (mismatches),
    .words_due_o          (words_due),
    .words_seen_o         (words_seen)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL keypad_pin_entry_collector");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_event(input logic [OP_W-1:0] op_v, input logic [KEY_W-1:0] key_v,
                            input logic last_v);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push     <= 1'b1;
    op       <= op_v;
    key_code <= key_v;
    last_key <= last_v;
    @(posedge clk);
    while (full) @(posedge clk);
    events_sent++;
  endtask

  task automatic drain_and_settle();
    push <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reload(input logic [CD_W-1:0] value);
    drain_and_settle();
    cfg_we     <= 1'b1;
    cfg_wdata  <= value;
    reload_now = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_digit();
    logic [KEY_W-1:0] k;
    k = KEY_CLEAR;
    while (k == KEY_CLEAR || k == KEY_ENTER) begin
      if ($urandom_range(1) == 0) k = KEY_W'(8'h30 + $urandom_range(9));
      else k = KEY_W'($urandom_range(255));
    end
    return k;
  endfunction

  // one entry with random digits, then a random way of ending it or none
  task automatic pin_sequence();
    int n_keys;
    int polls;
    n_keys = ($urandom_range(9) == 0) ? $urandom_range(27, 31) : $urandom_range(0, 8);
    for (int i = 0; i < n_keys; i++) begin
      if ($urandom_range(7) == 0)
        send_event(OP_POLL, KEY_W'($urandom_range(255)), 1'($urandom_range(1)));
      send_event(OP_KEY, pick_digit(), ($urandom_range(3) == 0));
    end
    case ($urandom_range(9))
      5: begin
        polls = (reload_now <= 6) ? int'(reload_now) + 2 : 3;
        repeat (polls) send_event(OP_POLL, KEY_W'($urandom_range(255)), 1'($urandom_range(1)));
      end
      6: send_event(OP_CARD, KEY_W'($urandom_range(255)), 1'($urandom_range(1)));
      7: send_event(OP_CLEAR, KEY_W'($urandom_range(255)), 1'($urandom_range(1)));
      8: send_event(OP_KEY, KEY_CLEAR, 1'($urandom_range(1)));
      9: ;
      default: send_event(OP_KEY, KEY_ENTER, 1'($urandom_range(1)));
    endcase
  endtask

  task automatic random_segment(input int sender_pct, input int receiver_pct,
                                input logic [CD_W-1:0] reload_v);
    int stop_at;
    write_reload(reload_v);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
    stop_at = events_sent + SEGMENT_EVENTS;
    while (events_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 3))
          send_event(OP_W'($urandom_range(3)), KEY_W'($urandom_range(255)),
                     1'($urandom_range(1)));
      end else begin
        pin_sequence();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // timeout disabled from reset
    send_event(OP_KEY, KEY_ENTER, 1'b0);
    send_event(OP_KEY, 8'h00, 1'b0);
    send_event(OP_KEY, 8'hff, 1'b0);
    send_event(OP_KEY, 8'h31, 1'b0);
    send_event(OP_KEY, KEY_ENTER, 1'b1);
    send_event(OP_KEY, 8'h55, 1'b1);
    send_event(OP_POLL, 8'hff, 1'b1);
    send_event(OP_KEY, KEY_CLEAR, 1'b0);
    send_event(OP_KEY, KEY_ENTER, 1'b0);

    write_reload(16'd1);
    send_event(OP_KEY, 8'h42, 1'b0);
    send_event(OP_POLL, 8'h00, 1'b0);
    send_event(OP_POLL, 8'h00, 1'b0);
    send_event(OP_KEY, 8'h10, 1'b1);
    send_event(OP_POLL, 8'h00, 1'b0);
    send_event(OP_KEY, 8'h20, 1'b0);
    send_event(OP_CARD, 8'haa, 1'b1);
    send_event(OP_KEY, KEY_ENTER, 1'b0);
    send_event(OP_KEY, 8'h21, 1'b0);
    send_event(OP_CLEAR, KEY_ENTER, 1'b0);
    send_event(OP_POLL, 8'h00, 1'b0);
    // fill the store, then one more key overflows it
    for (int i = 0; i < PIN_DEPTH; i++) send_event(OP_KEY, KEY_W'(8'h30 + i), 1'b0);
    send_event(OP_KEY, 8'h7e, 1'b0);
    send_event(OP_KEY, KEY_ENTER, 1'b0);

    random_segment(37, 74, 16'd3);
    random_segment(74, 37, 16'hffff);
    random_segment(0, 0, 16'd0);
    random_segment(0, 0, 16'd2);

    drain_and_settle();
    $display("drove %0d keypad events across reload settings 0, 1, 2, 3 and 65535",
             events_sent);
    $display("checked %0d result words, %0d mismatches", words_seen, mismatches);
    if (mismatches == 0 && words_due == 0) begin
      $display("PASS keypad_pin_entry_collector");
    end else begin
      $display("FAIL keypad_pin_entry_collector");
    end
    $finish;
  end

endmodule
